FILE: sv/fte_pkg.sv
package fte_pkg;

  // Field and register widths
  localparam int ADDR_W     = 32;
  localparam int TCP_PORT_W = 16;
  localparam int ING_W      = 6;
  localparam int HOP_W      = 8;
  localparam int ARITY_W    = 7;
  localparam int NODE_W     = 17;
  localparam int SPRAY_W    = 1;
  localparam int EGRESS_W   = 6;
  localparam int CFG_DATA_W = 17;
  localparam int CFG_IDX_W  = 2;

  // Derived datapath widths (k is at most 127)
  localparam int HALF_W   = ARITY_W - 1;   // k/2
  localparam int SQ_W     = 2 * ARITY_W;   // k*k
  localparam int CUBE_W   = 21;            // k*k*k, 127^3 < 2^21
  localparam int TIER_W   = 20;            // k^3/4 + k^2 < 2^20
  localparam int HASH_W   = 16;

  // Shared divider
  localparam int DVND_W    = 32;
  localparam int DVSR_W    = SQ_W - 2;     // k*k/4
  localparam int DIV_BITS  = 4;
  localparam int DIV_STEPS = DVND_W / DIV_BITS;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TREE_ARITY  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_NUMBER = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPRAY_MODE  = 2'd2;

  localparam logic [ARITY_W-1:0] ARITY_RESET = 7'd4;
  localparam logic [HASH_W-1:0]  LFSR_TAPS   = 16'hB400;
  localparam logic [HASH_W-1:0]  LFSR_SEED   = 16'h0001;
  localparam logic [HOP_W-1:0]   HOP_MAX     = 8'hFF;
  localparam logic [HOP_W-1:0]   HOP_DOWN    = 8'd2;
  localparam logic [DVND_W-1:0]  EGRESS_MAX  = 32'd63;

  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_SQ,
    ST_MUL_CUBE,
    ST_PLAN,
    ST_DIV,
    ST_FINISH
  } seq_state_t;

  typedef enum logic [1:0] {
    RT_EDGE,
    RT_AGG,
    RT_CORE,
    RT_UP
  } route_t;

endpackage

FILE: sv/fat_tree_ecmp_next_hop.sv
// Channel  | Direction | Handshake          | Payload
// ---------+-----------+--------------------+---------------------------------------------
// in_      | request   | in_valid/in_stall  | addresses, TCP ports, ingress port, hops
// out_     | result    | out_valid/out_stall| deliver_local, egress_port, range flag, hops
// cfg_     | write     | cfg_we             | cfg_index selects arity, node number, spray
//
// One request at a time: from accept to the result register it passes the square and
// cube multiply states, a planning state, 8 steps of the shared divider (4 quotient bits
// per step) and a finish state; the next request is taken only back in the idle state.
// Aggregation tier: a second division. Local delivery skips the divider.
// Reset (synchronous, rst_n low) restores the register defaults and seeds the LFSR.
// A result waits in the output register while the next request is taken; hold the
// sequencer only when a new result finds that register still stalled.
module fat_tree_ecmp_next_hop import fte_pkg::*; #(
  parameter int MAX_ARITY = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [ADDR_W-1:0]     in_source_address,
  input  logic [ADDR_W-1:0]     in_dest_address,
  input  logic [TCP_PORT_W-1:0] in_source_port,
  input  logic [TCP_PORT_W-1:0] in_dest_port,
  input  logic [ING_W-1:0]      in_ingress_port,
  input  logic [HOP_W-1:0]      in_hop_count,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_deliver_local,
  output logic [EGRESS_W-1:0]   out_egress_port,
  output logic                  out_port_out_of_range,
  output logic [HOP_W-1:0]      out_hop_count_next,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Configuration registers
  logic [ARITY_W-1:0] tree_arity_r;
  logic [NODE_W-1:0]  node_number_r;
  logic               spray_mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tree_arity_r  <= ARITY_RESET;
      node_number_r <= '0;
      spray_mode_r  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TREE_ARITY:  tree_arity_r  <= cfg_data[ARITY_W-1:0];
        CFG_NODE_NUMBER: node_number_r <= cfg_data[NODE_W-1:0];
        CFG_SPRAY_MODE:  spray_mode_r  <= cfg_data[SPRAY_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective arity, saturated to MAX_ARITY
  localparam logic [ARITY_W:0] ARITY_CAP = (ARITY_W + 1)'(MAX_ARITY);

  logic [ARITY_W-1:0] k_w;
  logic [HALF_W-1:0]  half_w;

  assign k_w    = ({1'b0, tree_arity_r} > ARITY_CAP) ? ARITY_CAP[ARITY_W-1:0] : tree_arity_r;
  assign half_w = k_w[ARITY_W-1:1];

  // Sequencer and request registers
  seq_state_t state_r, state_nxt;

  logic [ADDR_W-1:0]     src_r;
  logic [ADDR_W-1:0]     dst_r;
  logic [TCP_PORT_W-1:0] sport_r;
  logic [TCP_PORT_W-1:0] dport_r;
  logic [ING_W-1:0]      ing_r;
  logic [HOP_W-1:0]      hop_r;
  logic [SQ_W-1:0]       sq_r;
  logic [CUBE_W-1:0]     cube_r;
  route_t                route_r;
  logic                  pass2_r;
  logic                  local_r;
  logic [DVND_W-1:0]     port_r;
  logic [HASH_W-1:0]     lfsr_r;

  logic                  in_accept;
  logic                  out_load;
  logic                  is_local;
  route_t                route_sel;
  logic [HASH_W-1:0]     fold_w;
  logic [HASH_W-1:0]     lfsr_step;
  logic [HASH_W-1:0]     hash_w;
  logic [TIER_W-1:0]     edge_lim;
  logic [TIER_W-1:0]     agg_lim;
  logic [TIER_W-1:0]     node_ext;
  logic [DVSR_W-1:0]     quarter_sq;

  div_ctl_t              div_ctl;
  div_sts_t              div_sts;
  logic [DVND_W-1:0]     div_dividend;
  logic [DVSR_W-1:0]     div_divisor;
  logic [DVND_W-1:0]     div_quot;
  logic [DVSR_W-1:0]     div_rem;

  assign in_accept  = in_valid && !in_stall;
  assign is_local   = (dst_r == ADDR_W'(node_number_r));
  assign quarter_sq = sq_r[SQ_W-1:2];

  // Flow hash: XOR fold of the header fields
  assign fold_w = src_r[HASH_W-1:0] ^ src_r[ADDR_W-1:HASH_W] ^ sport_r ^ dport_r ^
                  dst_r[HASH_W-1:0] ^ dst_r[ADDR_W-1:HASH_W] ^ HASH_W'(ing_r);

  // Galois LFSR, one step per sprayed up-bound request
  assign lfsr_step = lfsr_r[0] ? ((lfsr_r >> 1) ^ LFSR_TAPS) : (lfsr_r >> 1);
  assign hash_w    = spray_mode_r ? lfsr_step : fold_w;

  // Tier boundaries: servers k^3/4, then edge k^2/2, then aggregation k^2/2
  assign node_ext = TIER_W'(node_number_r);
  assign edge_lim = TIER_W'(cube_r >> 2) + TIER_W'(sq_r >> 1);
  assign agg_lim  = TIER_W'(cube_r >> 2) + TIER_W'(sq_r);

  always_comb begin
    if (hop_r < HOP_DOWN) begin
      route_sel = RT_UP;
    end else if (node_ext < edge_lim) begin
      route_sel = RT_EDGE;
    end else if (node_ext < agg_lim) begin
      route_sel = RT_AGG;
    end else begin
      route_sel = RT_CORE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state, divider launch and operand selection
  always_comb begin
    state_nxt     = state_r;
    div_ctl.start = 1'b0;
    div_dividend  = dst_r;
    div_divisor   = quarter_sq;
    in_stall      = (state_r != ST_IDLE);
    out_load      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_MUL_SQ;
        end
      end
      ST_MUL_SQ: begin
        state_nxt = ST_MUL_CUBE;
      end
      ST_MUL_CUBE: begin
        state_nxt = ST_PLAN;
      end
      ST_PLAN: begin
        if (is_local) begin
          state_nxt = ST_FINISH;
        end else begin
          div_ctl.start = 1'b1;
          state_nxt     = ST_DIV;
          if (route_sel == RT_UP) begin
            div_dividend = DVND_W'(hash_w);
          end
          if (route_sel == RT_UP || route_sel == RT_EDGE) begin
            div_divisor = DVSR_W'(half_w);
          end
        end
      end
      ST_DIV: begin
        if (div_sts.done) begin
          if (route_r == RT_AGG && !pass2_r) begin
            // Second pass: remainder by k^2/4, then divide by k/2
            div_ctl.start = 1'b1;
            div_dividend  = DVND_W'(div_rem);
            div_divisor   = DVSR_W'(half_w);
          end else begin
            state_nxt = ST_FINISH;
          end
        end
      end
      ST_FINISH: begin
        if (!out_valid || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  fte_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (div_ctl),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .sts       (div_sts),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          src_r   <= in_source_address;
          dst_r   <= in_dest_address;
          sport_r <= in_source_port;
          dport_r <= in_dest_port;
          ing_r   <= in_ingress_port;
          hop_r   <= in_hop_count;
        end
      end
      ST_MUL_SQ: begin
        sq_r <= SQ_W'(k_w) * SQ_W'(k_w);
      end
      ST_MUL_CUBE: begin
        cube_r <= CUBE_W'(sq_r) * CUBE_W'(k_w);
      end
      ST_PLAN: begin
        local_r <= is_local;
        route_r <= route_sel;
        pass2_r <= 1'b0;
        if (is_local) begin
          port_r <= '0;
        end
      end
      ST_DIV: begin
        if (div_sts.done) begin
          if (route_r == RT_AGG && !pass2_r) begin
            pass2_r <= 1'b1;
          end else begin
            case (route_r)
              RT_EDGE: port_r <= DVND_W'(div_rem);
              RT_UP:   port_r <= DVND_W'(div_rem) + DVND_W'(half_w);
              default: port_r <= div_quot;
            endcase
          end
        end
      end
      default: ;
    endcase
  end

  // Spray LFSR: advance only for a forwarded, up-bound request in spray mode
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lfsr_r <= LFSR_SEED;
    end else if (state_r == ST_PLAN && !is_local && route_sel == RT_UP && spray_mode_r) begin
      lfsr_r <= lfsr_step;
    end
  end

  // Output register
  logic                out_valid_r;
  logic                deliver_r;
  logic [EGRESS_W-1:0] egress_r;
  logic                range_r;
  logic [HOP_W-1:0]    hop_next_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      deliver_r <= local_r;
      egress_r  <= port_r[EGRESS_W-1:0];
      range_r   <= !local_r && ((port_r >= DVND_W'(k_w)) || (port_r > EGRESS_MAX));
      if (local_r || hop_r == HOP_MAX) begin
        hop_next_r <= hop_r;
      end else begin
        hop_next_r <= hop_r + 1'b1;
      end
    end
  end

  assign out_valid             = out_valid_r;
  assign out_deliver_local     = deliver_r;
  assign out_egress_port       = egress_r;
  assign out_port_out_of_range = range_r;
  assign out_hop_count_next    = hop_next_r;

endmodule

FILE: sv/fte_div.sv
module fte_div import fte_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  div_ctl_t          ctl,
  input  logic [DVND_W-1:0] dividend,
  input  logic [DVSR_W-1:0] divisor,
  output div_sts_t          sts,
  output logic [DVND_W-1:0] quotient,
  output logic [DVSR_W-1:0] remainder
);

  localparam int CNT_W = $clog2(DIV_STEPS);

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [DVND_W-1:0] quo_r;
  logic [DVND_W-1:0] quo_nxt;
  logic [DVSR_W-1:0] rem_r;
  logic [DVSR_W-1:0] rem_nxt;
  logic [DVSR_W-1:0] dvsr_r;
  logic              zero_r;

  // Restoring division, DIV_BITS quotient bits per cycle
  always_comb begin
    logic [DVSR_W:0]   r;
    logic [DVND_W-1:0] q;
    r = {1'b0, rem_r};
    q = quo_r;
    for (int i = 0; i < DIV_BITS; i++) begin
      r = {r[DVSR_W-1:0], q[DVND_W-1]};
      q = {q[DVND_W-2:0], 1'b0};
      if (r >= {1'b0, dvsr_r}) begin
        r    = r - {1'b0, dvsr_r};
        q[0] = 1'b1;
      end
    end
    rem_nxt = r[DVSR_W-1:0];
    quo_nxt = q;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      quo_r  <= dividend;
      rem_r  <= '0;
      dvsr_r <= divisor;
      zero_r <= (divisor == '0);
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  // A zero divisor gives zero for both results
  assign quotient  = zero_r ? '0 : quo_r;
  assign remainder = zero_r ? '0 : rem_r;
  assign sts.busy  = busy_r;
  assign sts.done  = done_r;

endmodule

FILE: tb/fat_tree_ecmp_next_hop_tb.sv
`timescale 1ns / 100ps

module fat_tree_ecmp_next_hop_tb;
  import fte_pkg::*;

  localparam int unsigned TREE_MAX    = 64;
  localparam int unsigned NODE_MAX    = 131071;
  localparam int unsigned PORT_FIELD  = 63;
  localparam int unsigned DOWN_HOPS   = 2;
  localparam logic [15:0] SPRAY_POLY  = 16'hB400;
  localparam logic [15:0] SPRAY_SEED  = 16'h0001;
  localparam int          SETTLE      = 40;       // covers the slowest request (two divisions)
  localparam int          CYCLE_LIMIT = 500000;
  localparam int          PHASES      = 11;
  localparam int          PHASE_REQS  = 100;

  // Arity per random phase; the last one is replaced by a random even value
  localparam int unsigned PHASE_ARITY [PHASES] = '{4, 8, 64, 64, 0, 1, 127, 5, 2, 16, 0};

  typedef struct packed {
    logic [ADDR_W-1:0]     src_addr;
    logic [ADDR_W-1:0]     dst_addr;
    logic [TCP_PORT_W-1:0] src_port;
    logic [TCP_PORT_W-1:0] dst_port;
    logic [ING_W-1:0]      ingress;
    logic [HOP_W-1:0]      hops;
  } hdr_t;

  typedef struct packed {
    logic                deliver;
    logic [EGRESS_W-1:0] egress;
    logic                out_of_range;
    logic [HOP_W-1:0]    hops_next;
  } fwd_t;

  typedef enum int {TIER_LOW, TIER_AGG, TIER_CORE} tier_t;
  typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_style_t;

  // Forwarding decisions owed by the block, plus its own copy of the registers
  // and the spray LFSR.
  class egress_checker;
    int unsigned arity;
    int unsigned node;
    bit          spray;
    logic [15:0] lfsr;
    fwd_t        egress_due_q[$];
    int          errors;

    function new();
      arity  = ARITY_RESET;
      node   = 0;
      spray  = 1'b0;
      lfsr   = SPRAY_SEED;
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, int unsigned value);
      case (idx)
        CFG_TREE_ARITY:  arity = value & 32'h7F;
        CFG_NODE_NUMBER: node  = value & 32'h1FFFF;
        CFG_SPRAY_MODE:  spray = value[0];
        default: ;
      endcase
    endfunction

    function int unsigned mod_or_zero(int unsigned a, int unsigned b);
      return (b == 0) ? 0 : a % b;
    endfunction

    function int unsigned div_or_zero(int unsigned a, int unsigned b);
      return (b == 0) ? 0 : a / b;
    endfunction

    function fwd_t pick_egress(hdr_t h);
      int unsigned k, half, quarter_sq, srv_num, sw_num, port;
      logic [15:0] hash;
      logic        carry;
      fwd_t        f;
      k          = (arity > TREE_MAX) ? TREE_MAX : arity;
      half       = k / 2;
      quarter_sq = (k * k) / 4;
      srv_num    = (k * k * k) / 4;
      sw_num     = k * k;
      if (h.dst_addr == ADDR_W'(node)) begin
        // not forwarded: hop count unchanged, LFSR holds
        f.deliver      = 1'b1;
        f.egress       = '0;
        f.out_of_range = 1'b0;
        f.hops_next    = h.hops;
        return f;
      end
      if (h.hops >= DOWN_HOPS) begin
        if (node < srv_num + sw_num / 2)
          port = mod_or_zero(h.dst_addr, half);
        else if (node < srv_num + sw_num)
          port = div_or_zero(mod_or_zero(h.dst_addr, quarter_sq), half);
        else
          port = div_or_zero(h.dst_addr, quarter_sq);
      end else begin
        if (spray) begin
          carry = lfsr[0];
          lfsr  = lfsr >> 1;
          if (carry)
            lfsr = lfsr ^ SPRAY_POLY;
          hash = lfsr;
        end else begin
          hash = h.src_addr[15:0] ^ h.src_addr[31:16] ^ h.src_port ^ h.dst_port ^
                 h.dst_addr[15:0] ^ h.dst_addr[31:16] ^ 16'(h.ingress);
        end
        port = mod_or_zero(hash, half) + half;
      end
      f.deliver      = 1'b0;
      f.egress       = EGRESS_W'(port);
      f.out_of_range = (port >= k) || (port > PORT_FIELD);
      f.hops_next    = (h.hops == HOP_MAX) ? HOP_MAX : h.hops + 8'd1;
      return f;
    endfunction

    task report(string msg);
      errors++;
      $display("[%0t] mismatch: %s", $time, msg);
    endtask

    function void note_request(hdr_t h);
      egress_due_q.push_back(pick_egress(h));
    endfunction

    task check_result(fwd_t got);
      fwd_t want;
      if (egress_due_q.size() == 0) begin
        report($sformatf("result with no request waiting (egress %0d)", got.egress));
        return;
      end
      want = egress_due_q.pop_front();
      if (got.deliver !== want.deliver)
        report($sformatf("deliver_local %b, want %b", got.deliver, want.deliver));
      if (got.egress !== want.egress)
        report($sformatf("egress_port %0d, want %0d", got.egress, want.egress));
      if (got.out_of_range !== want.out_of_range)
        report($sformatf("port_out_of_range %b, want %b", got.out_of_range, want.out_of_range));
      if (got.hops_next !== want.hops_next)
        report($sformatf("hop_count_next %0d, want %0d", got.hops_next, want.hops_next));
    endtask

    function int pending();
      return egress_due_q.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  hdr_t                  req_bus = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_deliver_local;
  logic [EGRESS_W-1:0]   out_egress_port;
  logic                  out_port_out_of_range;
  logic [HOP_W-1:0]      out_hop_count_next;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_TREE_ARITY;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  fwd_t                  dut_result;

  egress_checker sb;
  int            burst_left = 0;
  int            cycle_count = 0;
  stall_style_t  stall_style = STALL_NONE;
  int unsigned   stall_left = 0;

  assign dut_result = {out_deliver_local, out_egress_port, out_port_out_of_range,
                       out_hop_count_next};

  fat_tree_ecmp_next_hop #(.MAX_ARITY(TREE_MAX)) dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_source_address     (req_bus.src_addr),
    .in_dest_address       (req_bus.dst_addr),
    .in_source_port        (req_bus.src_port),
    .in_dest_port          (req_bus.dst_port),
    .in_ingress_port       (req_bus.ingress),
    .in_hop_count          (req_bus.hops),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_deliver_local     (out_deliver_local),
    .out_egress_port       (out_egress_port),
    .out_port_out_of_range (out_port_out_of_range),
    .out_hop_count_next    (out_hop_count_next),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Sample both handshakes with the values that stood before the edge.
  // A request is noted before a result is checked; the block never turns a
  // request around within the same edge.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall)
      sb.note_request(req_bus);
    if (rst_n && out_valid && !out_stall)
      sb.check_result(dut_result);
  end

  // Receiver back-pressure: switch between a few stall styles every so often,
  // so that stretches of free flow alternate with light, heavy and periodic stalls.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_style <= stall_style_t'($urandom_range(0, 3));
      stall_left  <= $urandom_range(20, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_style)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default:     out_stall <= (stall_left[3:0] < 4'd6);
    endcase
  end

  // Hand one request to the block and hold it until it is taken. Requests go
  // out in bursts; between bursts drop valid for a random gap, and now and
  // then hold off until every owed result has come back.
  task automatic send(input hdr_t h);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      if ($urandom_range(0, 15) == 0) begin
        while (sb.pending() != 0)
          @(posedge clk);
      end
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
    req_bus  <= h;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
    burst_left--;
  endtask

  // Write all three registers, only once the block has gone quiet.
  task automatic configure(input int unsigned arity, input int unsigned node, input bit spray);
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_TREE_ARITY;
    cfg_data  <= CFG_DATA_W'(arity);
    sb.set_reg(CFG_TREE_ARITY, arity);
    @(posedge clk);
    cfg_index <= CFG_NODE_NUMBER;
    cfg_data  <= CFG_DATA_W'(node);
    sb.set_reg(CFG_NODE_NUMBER, node);
    @(posedge clk);
    cfg_index <= CFG_SPRAY_MODE;
    cfg_data  <= CFG_DATA_W'(spray);
    sb.set_reg(CFG_SPRAY_MODE, spray);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Edge cases for the current setting: local delivery at saturated hops, an
  // up request of zeros toward the node's complement, one of all ones, and two
  // down requests, the second to the top address (overflows the port field at the core).
  task automatic directed_set(input int unsigned arity, input int unsigned node,
                              input bit spray);
    configure(arity, node, spray);
    send(hdr_t'{32'hFFFF_FFFF, ADDR_W'(node), 16'hFFFF, 16'h0000, 6'd0, HOP_MAX});
    send(hdr_t'{32'h0, ~ADDR_W'(node), 16'h0, 16'h0, 6'd0, 8'd0});
    send(hdr_t'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 6'd63, 8'd1});
    send(hdr_t'{$urandom(), ADDR_W'(node + 1), 16'($urandom()), 16'($urandom()),
                6'($urandom()), HOP_DOWN});
    send(hdr_t'{$urandom(), 32'hFFFF_FFFF, 16'($urandom()), 16'($urandom()),
                6'($urandom()), HOP_MAX});
  endtask

  function automatic int unsigned tier_node(int unsigned arity, tier_t tier);
    int unsigned k, lo, hi;
    k = (arity > TREE_MAX) ? TREE_MAX : arity;
    case (tier)
      TIER_LOW: begin
        lo = 0;
        hi = (k * k * k) / 4 + (k * k) / 2;
      end
      TIER_AGG: begin
        lo = (k * k * k) / 4 + (k * k) / 2;
        hi = (k * k * k) / 4 + k * k;
      end
      default: begin
        lo = (k * k * k) / 4 + k * k;
        hi = NODE_MAX + 1;
      end
    endcase
    return (hi > lo) ? $urandom_range(lo, hi - 1) : lo;
  endfunction

  // Random header biased toward this node, its neighbors and addresses inside
  // the tree, with hop counts that favor the up/down boundary and saturation.
  function automatic hdr_t random_header();
    hdr_t        h;
    int unsigned k, span;
    k    = (sb.arity > TREE_MAX) ? TREE_MAX : sb.arity;
    span = (k * k * k) / 4 + k * k + 64;
    h.src_addr = $urandom();
    h.src_port = 16'($urandom());
    h.dst_port = 16'($urandom());
    h.ingress  = 6'($urandom_range(0, 63));
    case ($urandom_range(0, 9))
      0:       h.dst_addr = ADDR_W'(sb.node);
      1:       h.dst_addr = ADDR_W'(sb.node + $urandom_range(1, 8));
      2, 3:    h.dst_addr = $urandom_range(0, span);
      default: h.dst_addr = $urandom();
    endcase
    case ($urandom_range(0, 7))
      0, 1, 2: h.hops = 8'($urandom_range(0, 1));
      3, 4:    h.hops = 8'($urandom_range(2, 6));
      5:       h.hops = 8'($urandom_range(253, 255));
      default: h.hops = 8'($urandom());
    endcase
    return h;
  endfunction

  initial begin
    while (cycle_count < CYCLE_LIMIT)
      @(posedge clk);
    $display("fat_tree_ecmp_next_hop_tb failed");
    $finish;
  end

  initial begin
    int unsigned arity;
    int unsigned node;
    bit          spray;
    sb = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset setting, aggregation with spraying, odd arity at the
    // core, zero arity, and arity beyond the maximum.
    directed_set(4, 0, 1'b0);
    directed_set(4, 26, 1'b1);
    directed_set(5, 60, 1'b0);
    directed_set(0, 5, 1'b1);
    directed_set(127, 69000, 1'b0);

    // Random phases, each under its own setting.
    for (int p = 0; p < PHASES; p++) begin
      arity = (p == PHASES - 1) ? 2 * $urandom_range(1, 32) : PHASE_ARITY[p];
      node  = (p == 3) ? NODE_MAX : tier_node(arity, tier_t'(p % 3));
      spray = p[0];
      configure(arity, node, spray);
      repeat (PHASE_REQS) send(random_header());
    end

    // Drain, then leave room for any stray result.
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (sb.errors == 0)
      $display("fat_tree_ecmp_next_hop_tb passed");
    else
      $display("fat_tree_ecmp_next_hop_tb failed");
    $finish;
  end

endmodule
